// ===== rtl/core/telnet_rx_option_refuser_assert.svh =====
// ============================================================================
// telnet_rx_option_refuser_assert.svh
// Assertion macros shared by the receive parser modules. Both sample on the
// rising edge of clock and are disabled while reset is high.
// ============================================================================
`ifndef TELNET_RX_OPTION_REFUSER_ASSERT_SVH
`define TELNET_RX_OPTION_REFUSER_ASSERT_SVH

// Property holds at every sampled edge
`define TROR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TROR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tror_pkg.sv =====
// ============================================================================
// tror_pkg
// Byte codes, result kinds and the result descriptor shared by the TELNET
// receive parser modules.
// ============================================================================
package tror_pkg;

   // TELNET framing bytes
   localparam logic [7:0] BYTE_IAC  = 8'hFF;
   localparam logic [7:0] BYTE_WILL = 8'd251;
   localparam logic [7:0] BYTE_DO   = 8'd253;
   localparam logic [7:0] BYTE_WONT = 8'hFC;
   localparam logic [7:0] BYTE_CR   = 8'h0D;
   localparam logic [7:0] BYTE_NUL  = 8'h00;

   // Result kinds
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   // Position of each byte within the three-byte refusal
   localparam logic [1:0] REPLY_IDX_IAC  = 2'd0;
   localparam logic [1:0] REPLY_IDX_WONT = 2'd1;
   localparam logic [1:0] REPLY_IDX_LAST = 2'd2;

   // Decoded result for one received byte
   typedef struct packed {
      logic       refuse;  // 1: IAC WONT option reply, 0: one data byte
      logic [7:0] data;    // data byte or option code
   } res_desc_type;

endpackage

// ===== rtl/core/tror_parse.sv =====
// ============================================================================
// tror_parse
// Input register and TELNET framing decoder. Holds the parse state and the
// pending command byte, and hands at most one result descriptor per byte onward.
// ============================================================================
`include "telnet_rx_option_refuser_assert.svh"

module tror_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  telnet_mode,
   input  logic                  req_valid,
   input  logic [7:0]            req_rx_byte,
   output logic                  req_stall,
   output logic                  res_valid,
   output tror_pkg::res_desc_type res_desc,
   input  logic                  res_free
);
   import tror_pkg::*;

   typedef enum logic [1:0] {
      ST_DATA = 2'd0,
      ST_IAC  = 2'd1,
      ST_CMD  = 2'd2,
      ST_CR   = 2'd3
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] cmd_ff, cmd_in;
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       emit;
   logic       refuse;
   logic       as_data;
   logic       adv;

   // Decode the held byte against the current state
   always_comb begin
      emit     = 1'b0;
      refuse   = 1'b0;
      as_data  = 1'b0;
      state_in = state_ff;
      cmd_in   = cmd_ff;
      if (!telnet_mode) begin
         emit = 1'b1;
      end else begin
         unique case (state_ff)
            ST_DATA: begin
               as_data = 1'b1;
            end
            ST_IAC: begin
               if (in_byte_ff == BYTE_IAC) begin
                  emit     = 1'b1;
                  state_in = ST_DATA;
               end else begin
                  cmd_in   = in_byte_ff;
                  state_in = ST_CMD;
               end
            end
            ST_CMD: begin
               if (cmd_ff < BYTE_WILL) begin
                  as_data = 1'b1;
               end else begin
                  if (cmd_ff == BYTE_DO) begin
                     emit   = 1'b1;
                     refuse = 1'b1;
                  end
                  state_in = ST_DATA;
               end
            end
            ST_CR: begin
               if (in_byte_ff == BYTE_NUL) begin
                  state_in = ST_DATA;
               end else begin
                  as_data = 1'b1;
               end
            end
            default: begin
               state_in = ST_DATA;
            end
         endcase
         // Ordinary data handling, also after CR and one-byte commands
         if (as_data) begin
            if (in_byte_ff == BYTE_IAC) begin
               state_in = ST_IAC;
            end else begin
               emit     = 1'b1;
               state_in = (in_byte_ff == BYTE_CR) ? ST_CR : ST_DATA;
            end
         end
      end
   end

   // Byte moves on when it has no result or the result register is free
   assign adv             = in_vld_ff && (!emit || res_free);
   assign req_stall       = in_vld_ff && !adv;
   assign res_valid       = in_vld_ff && emit;
   assign res_desc.refuse = refuse;
   assign res_desc.data   = in_byte_ff;

   // Input register and parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         state_ff  <= ST_DATA;
         cmd_ff    <= 8'h00;
      end else begin
         if (!req_stall) begin
            in_vld_ff <= req_valid;
         end
         if (adv) begin
            state_ff <= state_in;
            cmd_ff   <= cmd_in;
         end
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Checks
   `TROR_ASSERT_NEXT(a_mode_off_holds_state, adv && !telnet_mode, $stable(state_ff) && $stable(cmd_ff), "parse state moved with TELNET mode off")
   `TROR_ASSERT(a_refuse_only_after_do, refuse |-> (state_ff == ST_CMD && cmd_ff == BYTE_DO), "refusal raised outside DO option")
   `TROR_ASSERT(a_cmd_state_has_cmd, (state_ff == ST_CMD) |-> (cmd_ff != BYTE_IAC), "command state holds IAC as command")

endmodule

// ===== rtl/core/tror_emit.sv =====
// ============================================================================
// tror_emit
// Result register. Delivers a data byte as one transaction, or expands a DO
// refusal into the three transactions IAC, WONT, option.
// ============================================================================
`include "telnet_rx_option_refuser_assert.svh"

module tror_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  tror_pkg::res_desc_type res_desc,
   output logic                  res_free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_out_kind,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last
);
   import tror_pkg::*;

   logic       res_vld_ff;
   logic       refuse_ff;
   logic [7:0] data_ff;
   logic [1:0] idx_ff;
   logic       out_fire;
   logic       load;

   assign rsp_valid    = res_vld_ff;
   assign rsp_out_kind = refuse_ff ? KIND_REPLY : KIND_DATA;
   assign rsp_last     = !refuse_ff || (idx_ff == REPLY_IDX_LAST);
   assign out_fire     = res_vld_ff && !rsp_stall;
   assign res_free     = !res_vld_ff || (!rsp_stall && rsp_last);
   assign load         = res_valid && res_free;

   // Byte on the wire for the current transaction
   always_comb begin
      if (!refuse_ff) begin
         rsp_out_byte = data_ff;
      end else begin
         unique case (idx_ff)
            REPLY_IDX_IAC:  rsp_out_byte = BYTE_IAC;
            REPLY_IDX_WONT: rsp_out_byte = BYTE_WONT;
            default:        rsp_out_byte = data_ff;
         endcase
      end
   end

   // Result register and refusal sequence counter
   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= 1'b0;
         idx_ff     <= REPLY_IDX_IAC;
      end else if (load) begin
         res_vld_ff <= 1'b1;
         idx_ff     <= REPLY_IDX_IAC;
      end else if (out_fire) begin
         if (rsp_last) begin
            res_vld_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
      if (load) begin
         refuse_ff <= res_desc.refuse;
         data_ff   <= res_desc.data;
      end
   end

   // Checks
   `TROR_ASSERT(a_idx_in_range, res_vld_ff |-> (idx_ff != 2'd3), "refusal counter out of range")
   `TROR_ASSERT(a_data_idx_zero, (res_vld_ff && !refuse_ff) |-> (idx_ff == REPLY_IDX_IAC), "data result with non-zero counter")
   `TROR_ASSERT_NEXT(a_drain_empties, out_fire && rsp_last && !load, !res_vld_ff, "result register not emptied after last transaction")

endmodule

// ===== rtl/core/telnet_rx_option_refuser.sv =====
// ============================================================================
// telnet_rx_option_refuser - TELNET receive framing stripper, refuses DO
// Path: a byte goes through the input register, then the result register.
// Throughput: a byte per cycle if not stalled; refusals hold the result register.
// Reset: synchronous; parse state to data, TELNET mode on, both registers empty.
// ============================================================================
module telnet_rx_option_refuser (
   input  logic        clock,
   input  logic        reset,
   // Received bytes
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // Host data and network replies
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   // Register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tror_pkg::*;

   localparam logic REG_TELNET_MODE = 1'b0;  // register index from paddr[2]

   logic         mode_ff;
   logic         csr_wr;
   logic         res_valid;
   logic         res_free;
   res_desc_type res_desc;

   // Register port: single mode bit at offset zero
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TELNET_MODE);
   assign prdata = (paddr[2] == REG_TELNET_MODE) ? {31'b0, mode_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_wr) begin
         mode_ff <= pwdata[0];
      end
   end

   tror_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .telnet_mode (mode_ff),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .res_valid   (res_valid),
      .res_desc    (res_desc),
      .res_free    (res_free)
   );

   tror_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .res_valid    (res_valid),
      .res_desc     (res_desc),
      .res_free     (res_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== sim/tb_telnet_rx_option_refuser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_telnet_rx_option_refuser
// Self-checking bench for the TELNET receive framing stripper. Received bytes
// are pushed through the input channel with random gaps. A behavioural parser
// in the bench predicts the host data bytes and the IAC WONT refusals, and
// every result transaction is checked field by field in order. The mode
// register is changed over the APB port between traffic phases.
// ----------------------------------------------------------------------------
module tb_telnet_rx_option_refuser;
   import tror_pkg::*;

   // Parser states of the behavioural copy
   typedef enum logic [1:0] {PS_DATA, PS_IAC, PS_CMD, PS_CR} parse_st_type;

   // One byte leaving the parser, toward the host or the network
   typedef struct packed {
      logic       kind;
      logic [7:0] val;
      logic       last;
   } parsed_byte_type;

   localparam logic [2:0] CSR_TELNET_MODE = 3'd0;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_out_kind;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // Behavioural parser state and the bytes it still owes
   logic            telnet_on;
   parse_st_type    parse_st;
   logic [7:0]      cmd_byte;
   parsed_byte_type owed_bytes [$];
   parsed_byte_type due;

   int  errors;
   int  bytes_sent;
   logic calm;

   telnet_rx_option_refuser dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   // Work out what one received byte produces and queue it
   function automatic void strip_framing(input logic [7:0] b);
      parsed_byte_type res [3];
      int   n;
      logic as_data;
      n = 0;
      as_data = 1'b0;
      if (!telnet_on) begin
         res[n] = '{KIND_DATA, b, 1'b0};
         n++;
      end else begin
         case (parse_st)
            PS_DATA: as_data = 1'b1;
            PS_IAC: begin
               if (b == BYTE_IAC) begin
                  res[n] = '{KIND_DATA, b, 1'b0};
                  n++;
                  parse_st = PS_DATA;
               end else begin
                  cmd_byte = b;
                  parse_st = PS_CMD;
               end
            end
            PS_CMD: begin
               if (cmd_byte < BYTE_WILL) begin
                  as_data = 1'b1;
               end else begin
                  // option byte: dropped, DO is refused
                  if (cmd_byte == BYTE_DO) begin
                     res[0] = '{KIND_REPLY, BYTE_IAC, 1'b0};
                     res[1] = '{KIND_REPLY, BYTE_WONT, 1'b0};
                     res[2] = '{KIND_REPLY, b, 1'b0};
                     n = 3;
                  end
                  parse_st = PS_DATA;
               end
            end
            default: begin
               if (b == BYTE_NUL) parse_st = PS_DATA;
               else as_data = 1'b1;
            end
         endcase
         // data-state handling, shared by the states that fall back to it
         if (as_data) begin
            if (b == BYTE_IAC) begin
               parse_st = PS_IAC;
            end else begin
               res[n] = '{KIND_DATA, b, 1'b0};
               n++;
               parse_st = (b == BYTE_CR) ? PS_CR : PS_DATA;
            end
         end
      end
      if (n > 0) res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) owed_bytes.push_back(res[i]);
   endfunction

   // Send one received byte; prediction happens at the accepting edge
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      strip_framing(b);
      bytes_sent++;
   endtask

   // Let the parser drain before touching the register
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (owed_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write the mode register, then read it back
   task automatic csr_write_mode(input logic mode);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_TELNET_MODE;
      pwdata  = {31'($urandom_range(0, 32'h7FFF_FFFF)), mode};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      telnet_on = mode;
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[0] !== mode) report_mismatch("telnet_mode readback", prdata[0], mode);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Framing rules from reset, mode on
   task automatic test_framing_rules();
      logic [7:0] seq [$];
      seq = '{8'h00, 8'h7F, 8'h80, 8'hFE,                 // plain data extremes
              BYTE_IAC, BYTE_IAC,                         // doubled IAC
              BYTE_IAC, 8'hF1, 8'h41,                     // one-byte command, then data
              BYTE_IAC, 8'd250, BYTE_IAC, BYTE_IAC,       // IAC right after a command
              BYTE_IAC, BYTE_WILL, 8'h01,
              BYTE_IAC, BYTE_WONT, 8'h00,
              BYTE_IAC, 8'd254, 8'hFF,                    // DONT, option dropped
              BYTE_IAC, BYTE_DO, 8'h18,                   // DO refused
              BYTE_IAC, BYTE_DO, BYTE_IAC,
              BYTE_CR, BYTE_NUL,                          // NUL after CR removed
              BYTE_CR, BYTE_CR, BYTE_NUL,
              BYTE_CR, 8'h0A,
              BYTE_CR, BYTE_IAC, BYTE_IAC,
              BYTE_IAC, 8'h00, BYTE_CR, BYTE_NUL};         // command 0, then CR NUL
      foreach (seq[i]) send_byte(seq[i]);
      settle();
   endtask

   // Mode off passes everything; state survives across the switch
   task automatic test_mode_switch();
      csr_write_mode(1'b1);
      send_byte(BYTE_IAC);
      settle();
      csr_write_mode(1'b0);
      send_byte(BYTE_IAC);
      send_byte(BYTE_CR);
      send_byte(BYTE_NUL);
      send_byte(BYTE_DO);
      settle();
      csr_write_mode(1'b1);
      send_byte(BYTE_DO);     // still after IAC: becomes the command
      send_byte(8'h01);
      settle();
   endtask

   // Mostly well-formed TELNET sequences with random content, plus noise
   task automatic send_traffic(input int count);
      int goal;
      goal = bytes_sent + count;
      while (bytes_sent < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2: send_byte($urandom_range(0, 255));
            3: begin
               send_byte(BYTE_IAC);
               send_byte(BYTE_IAC);
            end
            4: begin
               send_byte(BYTE_IAC);
               send_byte($urandom_range(0, 250));
               send_byte($urandom_range(0, 255));
            end
            5: begin
               send_byte(BYTE_IAC);
               send_byte($urandom_range(251, 254));
               send_byte($urandom_range(0, 255));
            end
            6: begin
               send_byte(BYTE_IAC);
               send_byte(BYTE_DO);
               send_byte($urandom_range(0, 255));
            end
            7: begin
               send_byte(BYTE_CR);
               send_byte(BYTE_NUL);
            end
            8: begin
               send_byte(BYTE_CR);
               send_byte($urandom_range(0, 255));
            end
            default: send_byte(BYTE_IAC);   // broken sequence
         endcase
      end
   endtask

   task automatic test_random_traffic();
      send_traffic(200);
      settle();
      csr_write_mode(1'b0);
      send_traffic(60);
      settle();
      csr_write_mode(1'b1);
      send_traffic(140);
      settle();
      // last stretch with both sides running flat out
      calm = 1'b1;
      send_traffic(100);
      settle();
   endtask

   // Receiver stalls in bursts, with quiet stretches between
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_stall = 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(8, 40)) @(negedge clock);
         end
      end
   end

   // Check each result transaction against the oldest owed byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_bytes.size() == 0) begin
            report_mismatch("unexpected result byte", rsp_out_byte, 0);
         end else begin
            due = owed_bytes.pop_front();
            if (rsp_out_kind !== due.kind) report_mismatch("out_kind", rsp_out_kind, due.kind);
            if (rsp_out_byte !== due.val)  report_mismatch("out_byte", rsp_out_byte, due.val);
            if (rsp_last !== due.last)     report_mismatch("last", rsp_last, due.last);
         end
      end
   end

   initial begin
      errors      = 0;
      bytes_sent  = 0;
      calm        = 1'b0;
      telnet_on   = 1'b1;
      parse_st    = PS_DATA;
      cmd_byte    = 8'h00;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = CSR_TELNET_MODE;
      pwdata      = 32'h0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_framing_rules();
      test_mode_switch();
      test_random_traffic();

      repeat (20) @(posedge clock);
      if (owed_bytes.size() != 0) report_mismatch("bytes never delivered", 0, owed_bytes.size());
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
